>>> design/cht_pkg.sv
// Shared constants, types and hash functions for the cuckoo hash table.
package cht_pkg;

    // Slots per table; a power of two, so both hashes reduce to bit fields.
    localparam int TBL_SIZE = 1024;
    localparam int TBL_AW   = $clog2(TBL_SIZE);

    localparam int KEY_W    = 31;
    localparam int ENTRY_W  = KEY_W + 1;
    localparam int SLOT_W   = 10;
    localparam int KICK_W   = 8;
    localparam int OP_W     = 2;
    localparam int STS_W    = 2;

    localparam logic [KICK_W-1:0] KICKS_RESET = 8'd32;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STS_W-1:0] STS_MISS = 2'd1;
    localparam logic [STS_W-1:0] STS_DUP  = 2'd2;
    localparam logic [STS_W-1:0] STS_FAIL = 2'd3;

    typedef struct packed {
        logic clr_wr;
        logic lookup;
        logic res_found;
        logic res_miss;
        logic res_dup;
        logic del_wr;
        logic ins_start;
        logic ins_place;
        logic ins_fail_limit;
        logic ins_kick;
        logic ins_fail_back;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit0;
        logic            hit1;
        logic            occ;
        logic            limit;
        logic            back;
        logic            clr_last;
        logic            out_free;
    } t_sts;

    function automatic logic [TBL_AW-1:0] hash0(input logic [KEY_W-1:0] k);
        return TBL_AW'(k % TBL_SIZE);
    endfunction

    function automatic logic [TBL_AW-1:0] hash1(input logic [KEY_W-1:0] k);
        return TBL_AW'((k / TBL_SIZE) % TBL_SIZE);
    endfunction

endpackage

>>> design/cuckoo_hash_table.sv
// Top level of the two-table cuckoo hash set.
// After reset both tables are swept empty, one slot of each per cycle, with
// o_stall high; configuration writes are taken during the sweep. One item is
// worked on at a time. A search, delete or duplicate insert passes from the
// check state to the finish state, where its result enters the output register
// and raises o_valid; an insert first walks the displacement chain, each step
// of which is one registered read of a table followed by an evaluate-and-write state.
// The next item is accepted the cycle after the result enters the output
// register, even while that result still waits for its transfer.
module cuckoo_hash_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cht_pkg::OP_W-1:0]    i_opcode,
    input  logic [cht_pkg::KEY_W-1:0]   i_key,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [cht_pkg::STS_W-1:0]   o_status,
    output logic                        o_which_table,
    output logic [cht_pkg::SLOT_W-1:0]  o_slot,
    output logic [cht_pkg::KEY_W-1:0]   o_homeless_key,
    input  logic                        i_cfg_wr_en,
    input  logic [cht_pkg::KICK_W-1:0]  i_cfg_wr_data
);
    import cht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    cht_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_opcode),
        .i_key          (i_key),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_which_table  (o_which_table),
        .o_slot         (o_slot),
        .o_homeless_key (o_homeless_key)
    );

endmodule

>>> design/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/cht_datapath.sv
// Datapath: both tables, key and chain registers, result and output registers.
module cht_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cht_pkg::t_cmd             i_cmd,
    output cht_pkg::t_sts             o_sts,
    input  logic [cht_pkg::OP_W-1:0]  i_opcode,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    input  logic                      i_cfg_wr_en,
    input  logic [cht_pkg::KICK_W-1:0] i_cfg_wr_data,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [cht_pkg::STS_W-1:0] o_status,
    output logic                      o_which_table,
    output logic [cht_pkg::SLOT_W-1:0] o_slot,
    output logic [cht_pkg::KEY_W-1:0] o_homeless_key
);
    import cht_pkg::*;

    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_cur;
    logic [KICK_W-1:0]  r_kicks;
    logic               r_tab;
    logic [TBL_AW-1:0]  r_clr_addr;
    logic [KICK_W-1:0]  r_max_kicks;

    logic [STS_W-1:0]   r_status;
    logic               r_which;
    logic [TBL_AW-1:0]  r_slot;
    logic [KEY_W-1:0]   r_homeless;

    logic               r_o_valid;
    logic [STS_W-1:0]   r_o_status;
    logic               r_o_which;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [KEY_W-1:0]   r_o_homeless;

    logic [KEY_W-1:0]   w_rd_key;
    logic [ENTRY_W-1:0] w_rd0;
    logic [ENTRY_W-1:0] w_rd1;
    logic [ENTRY_W-1:0] w_chain;
    logic               w_hit0;
    logic               w_hit1;
    logic               w_wr0;
    logic               w_wr1;
    logic [TBL_AW-1:0]  w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic               w_ins_wr;

    // Lookup reads the incoming key; otherwise read at the key being carried.
    assign w_rd_key = i_cmd.lookup ? i_key : r_cur;

    cht_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_SIZE)) u_tbl0 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr0),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (hash0(w_rd_key)),
        .o_rd_data (w_rd0)
    );

    cht_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_SIZE)) u_tbl1 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr1),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (hash1(w_rd_key)),
        .o_rd_data (w_rd1)
    );

    assign w_hit0  = w_rd0[KEY_W] && (w_rd0[KEY_W-1:0] == r_key);
    assign w_hit1  = w_rd1[KEY_W] && (w_rd1[KEY_W-1:0] == r_key);
    assign w_chain = r_tab ? w_rd1 : w_rd0;
    assign w_ins_wr = i_cmd.ins_place || i_cmd.ins_kick;

    always_comb begin
        w_wr0     = 1'b0;
        w_wr1     = 1'b0;
        w_wr_data = '0;
        w_wr_addr = r_tab ? hash1(r_cur) : hash0(r_cur);
        priority if (i_cmd.clr_wr) begin
            w_wr0     = 1'b1;
            w_wr1     = 1'b1;
            w_wr_addr = r_clr_addr;
        end else if (i_cmd.del_wr) begin
            w_wr0     = w_hit0;
            w_wr1     = !w_hit0;
            w_wr_addr = w_hit0 ? hash0(r_key) : hash1(r_key);
        end else if (w_ins_wr) begin
            w_wr0     = !r_tab;
            w_wr1     = r_tab;
            w_wr_data = {1'b1, r_cur};
        end else begin
            w_wr0     = 1'b0;
        end
    end

    always_comb begin
        o_sts.op       = r_op;
        o_sts.hit0     = w_hit0;
        o_sts.hit1     = w_hit1;
        o_sts.occ      = w_chain[KEY_W];
        o_sts.limit    = r_kicks >= r_max_kicks;
        o_sts.back     = w_chain[KEY_W-1:0] == r_key;
        o_sts.clr_last = r_clr_addr == TBL_AW'(TBL_SIZE - 1);
        o_sts.out_free = !r_o_valid || !i_stall;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_max_kicks <= KICKS_RESET;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_max_kicks <= i_cfg_wr_data;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        if (i_cmd.ins_start) begin
            r_cur   <= r_key;
            r_kicks <= '0;
            r_tab   <= 1'b0;
        end else if (i_cmd.ins_kick) begin
            r_cur   <= w_chain[KEY_W-1:0];
            r_kicks <= r_kicks + 1'b1;
            r_tab   <= !r_tab;
        end
        if (i_cmd.res_found || i_cmd.res_dup) begin
            r_status   <= i_cmd.res_dup ? STS_DUP : STS_OK;
            r_which    <= !w_hit0;
            r_slot     <= w_hit0 ? hash0(r_key) : hash1(r_key);
            r_homeless <= '0;
        end else if (i_cmd.res_miss) begin
            r_status   <= STS_MISS;
            r_which    <= 1'b0;
            r_slot     <= '0;
            r_homeless <= '0;
        end else if (i_cmd.ins_place) begin
            r_status   <= STS_OK;
            r_which    <= 1'b0;
            r_slot     <= hash0(r_key);
            r_homeless <= '0;
        end else if (i_cmd.ins_fail_limit || i_cmd.ins_fail_back) begin
            r_status   <= STS_FAIL;
            r_which    <= 1'b0;
            r_slot     <= '0;
            r_homeless <= i_cmd.ins_fail_back ? w_chain[KEY_W-1:0] : r_cur;
        end
        if (i_cmd.out_load) begin
            r_o_status   <= r_status;
            r_o_which    <= r_which;
            r_o_slot     <= SLOT_W'(r_slot);
            r_o_homeless <= r_homeless;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_which_table  = r_o_which;
    assign o_slot         = r_o_slot;
    assign o_homeless_key = r_o_homeless;

    a_kick_under_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_kick |-> (r_kicks < r_max_kicks))
        else $error("displacement past the kick limit");

    a_delete_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.del_wr |-> (w_hit0 || w_hit1))
        else $error("delete issued without a hit");

    a_out_load_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (o_valid && o_status == $past(r_status)
                            && o_homeless_key == $past(r_homeless)))
        else $error("output register did not take the result");

endmodule

>>> design/cht_ctrl.sv
// Controller state machine: clearing sweep, lookup, displacement chain, result hand-off.
module cht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cht_pkg::t_sts i_sts,
    output cht_pkg::t_cmd o_cmd
);
    import cht_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.lookup = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_FINISH;
                unique case (i_sts.op)
                    OP_SEARCH: begin
                        w_cmd.res_found = i_sts.hit0 || i_sts.hit1;
                        w_cmd.res_miss  = !(i_sts.hit0 || i_sts.hit1);
                    end
                    OP_DELETE: begin
                        w_cmd.res_found = i_sts.hit0 || i_sts.hit1;
                        w_cmd.del_wr    = i_sts.hit0 || i_sts.hit1;
                        w_cmd.res_miss  = !(i_sts.hit0 || i_sts.hit1);
                    end
                    OP_INSERT: begin
                        if (i_sts.hit0 || i_sts.hit1) begin
                            w_cmd.res_dup = 1'b1;
                        end else begin
                            w_cmd.ins_start = 1'b1;
                            n_state         = S_READ;
                        end
                    end
                    default: begin
                        w_cmd.res_miss = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                priority if (!i_sts.occ) begin
                    w_cmd.ins_place = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_sts.limit) begin
                    w_cmd.ins_fail_limit = 1'b1;
                    n_state              = S_FINISH;
                end else begin
                    // evict and carry the old key to the other table
                    w_cmd.ins_kick = 1'b1;
                    if (i_sts.back) begin
                        w_cmd.ins_fail_back = 1'b1;
                        n_state             = S_FINISH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_READ))
        else $error("chain evaluated without a preceding read");

    a_check_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(i_valid && !o_stall))
        else $error("check state entered without an input transfer");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a waiting result");

endmodule
